// ===== src/utcg_pkg.sv =====
// Shared types, constants and the glyph lookup for the UTF-8 text cursor glyph mapper.
// No dependencies; every other file in src imports this package.
package utcg_pkg;

    localparam int DISPLAY_WIDTH_DEF  = 128;
    localparam int DISPLAY_HEIGHT_DEF = 64;

    localparam int GLYPH_W     = 7;
    localparam int ADDR_W      = 10;
    localparam int COLUMN_W    = 7;
    localparam int PAGE_W      = 3;
    localparam int CHAR_ROWS   = 8;
    localparam int CHAR_STEP   = 8;

    localparam logic [GLYPH_W-1:0] GLYPH_BLANK      = 7'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_UPPER_BASE = 7'd1;
    localparam logic [GLYPH_W-1:0] GLYPH_DIGIT_BASE = 7'd27;
    localparam logic [GLYPH_W-1:0] GLYPH_LOWER_BASE = 7'd37;

    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       starts_string;
        logic [6:0] start_x;
        logic [5:0] start_y;
    } text_item_t;

    typedef struct packed {
        logic [GLYPH_W-1:0]  glyph_index;
        logic [ADDR_W-1:0]   byte_address;
        logic [COLUMN_W-1:0] column;
        logic [PAGE_W-1:0]   page;
    } glyph_item_t;

    // Result of one cursor step, handed to the output stage
    typedef struct packed {
        logic        emit;
        glyph_item_t item;
    } step_res_t;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] c);
        logic [GLYPH_W-1:0] g;
        g = GLYPH_BLANK;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            g = GLYPH_UPPER_BASE + GLYPH_W'(c - 8'h41);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            g = GLYPH_DIGIT_BASE + GLYPH_W'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            g = GLYPH_LOWER_BASE + GLYPH_W'(c - 8'h61);
        end
        else
        begin
            case (c)
                8'h2E:   g = 7'd63;
                8'h3A:   g = 7'd64;
                8'h23:   g = 7'd65;
                8'h21:   g = 7'd66;
                8'h3F:   g = 7'd67;
                8'hC3:   g = 7'd68;
                8'hC2:   g = 7'd69;
                8'hC1:   g = 7'd70;
                8'hC0:   g = 7'd71;
                8'hC9:   g = 7'd72;
                8'hCA:   g = 7'd73;
                8'hCD:   g = 7'd74;
                8'hD3:   g = 7'd75;
                8'hD4:   g = 7'd76;
                8'hD5:   g = 7'd77;
                8'hDA:   g = 7'd78;
                8'hC7:   g = 7'd79;
                8'hE7:   g = 7'd80;
                8'hE3:   g = 7'd81;
                8'hE1:   g = 7'd82;
                8'hE0:   g = 7'd83;
                8'hE2:   g = 7'd84;
                8'hE9:   g = 7'd85;
                8'hEA:   g = 7'd86;
                8'hED:   g = 7'd87;
                8'hF3:   g = 7'd88;
                8'hF4:   g = 7'd89;
                8'hFA:   g = 7'd90;
                8'h2C:   g = 7'd91;
                default: g = GLYPH_BLANK;
            endcase
        end
        return g;
    endfunction

endpackage

// ===== src/utf8_text_cursor_glyph_mapper_top.sv =====
// Top level of the UTF-8 text cursor glyph mapper: input register, cursor step, result register.
// Depends on utcg_pkg, utcg_cursor and utcg_out_stage.
//
// Usage:
//   text channel  (text_valid/text_ready/text_item): one UTF-8 byte per transaction,
//     with starts_string, start_x and start_y to open a new string at a position.
//   glyph channel (glyph_valid/glyph_ready/glyph_item): glyph index, framebuffer byte
//     address, column and page for each character that lands on the screen.
// Throughput: one byte per cycle unless the glyph channel stalls. Path: a byte accepted into
//   the input register reaches glyph_valid through the cursor step and the result register.
// Bytes that produce no glyph (lead bytes, skipped bytes, zero, off-screen or closed
//   string) update the cursor and vanish without touching the glyph channel.
// Stall: while glyph_valid waits for glyph_ready, one more byte may sit in the input
//   register; a byte that produces a glyph then holds there, and text_ready drops.
// Reset: cursor at 0,0, no pending lead byte, no open string, both registers empty.
module utf8_text_cursor_glyph_mapper_top #(
    parameter int DISPLAY_WIDTH  = utcg_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = utcg_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_ready,
    input  utcg_pkg::text_item_t  text_item,
    output logic                  glyph_valid,
    input  logic                  glyph_ready,
    output utcg_pkg::glyph_item_t glyph_item
);
    import utcg_pkg::*;

    logic       in_valid_reg, in_valid_next;
    text_item_t in_data_reg;
    step_res_t  res;
    logic       space;
    logic       step_en;

    // Advance the held byte unless it produces a glyph and the result register cannot take it
    assign step_en    = in_valid_reg && (!res.emit || space);
    assign text_ready = !in_valid_reg || step_en;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (text_valid && text_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            in_data_reg <= text_item;
        end
    end

    utcg_cursor #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_cursor (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_data_reg),
        .res     (res)
    );

    utcg_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step_en),
        .res         (res),
        .space       (space),
        .glyph_valid (glyph_valid),
        .glyph_ready (glyph_ready),
        .glyph_item  (glyph_item)
    );

endmodule

// ===== src/utcg_cursor.sv =====
// Cursor and UTF-8 lead state: decodes one byte, maps the glyph and moves the cursor.
// Depends on utcg_pkg (item types, glyph_of).
module utcg_cursor #(
    parameter int DISPLAY_WIDTH  = utcg_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = utcg_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  utcg_pkg::text_item_t  item,
    output utcg_pkg::step_res_t   res
);
    import utcg_pkg::*;

    localparam int CX_W = ($clog2(DISPLAY_WIDTH) > 7) ? $clog2(DISPLAY_WIDTH) : 7;
    localparam int CY_W = ($clog2(DISPLAY_HEIGHT) > 6) ? $clog2(DISPLAY_HEIGHT) : 6;
    localparam int PG_W = CY_W - 3;
    localparam int AW   = PG_W + CX_W + 2;
    localparam logic [CX_W:0] MAX_X = (CX_W+1)'(DISPLAY_WIDTH - CHAR_STEP);
    localparam logic [CY_W:0] MAX_Y = (CY_W+1)'(DISPLAY_HEIGHT - CHAR_ROWS);

    logic [CX_W-1:0] cx_reg, cx_next;
    logic [CY_W-1:0] cy_reg, cy_next;
    logic            lead_reg, lead_next;
    logic [1:0]      lbits_reg, lbits_next;
    logic            active_reg, active_next;

    logic [CX_W-1:0] x;
    logic [CY_W-1:0] y;
    logic            has_ch;
    logic [7:0]      ch;
    logic [CX_W:0]   x_sum;
    logic [CY_W:0]   y_sum;
    logic [PG_W-1:0] pg;
    logic [AW-1:0]   addr;

    always_comb
    begin
        x           = item.starts_string ? CX_W'(item.start_x) : cx_reg;
        y           = item.starts_string ? CY_W'(item.start_y) : cy_reg;
        lead_next   = item.starts_string ? 1'b0 : lead_reg;
        lbits_next  = item.starts_string ? 2'b00 : lbits_reg;
        active_next = item.starts_string | active_reg;
        has_ch      = 1'b0;
        ch          = item.text_byte;

        // Start row already past the last text row: close at once
        if (active_next && ({1'b0, y} > MAX_Y))
        begin
            active_next = 1'b0;
        end

        if (active_next)
        begin
            if (item.text_byte == CH_NUL)
            begin
                lead_next   = 1'b0;
                lbits_next  = 2'b00;
                active_next = 1'b0;
            end
            else if (lead_next)
            begin
                ch         = {lbits_next, item.text_byte[5:0]};
                has_ch     = 1'b1;
                lead_next  = 1'b0;
                lbits_next = 2'b00;
            end
            else if (!item.text_byte[7])
            begin
                has_ch = 1'b1;
            end
            else if (item.text_byte[7:5] == 3'b110)
            begin
                lead_next  = 1'b1;
                lbits_next = item.text_byte[1:0];
            end
        end

        x_sum   = {1'b0, x} + (CX_W+1)'(CHAR_STEP);
        y_sum   = {1'b0, y} + (CY_W+1)'(CHAR_ROWS);
        cx_next = x;
        cy_next = y;
        if (has_ch)
        begin
            if (x_sum > MAX_X)
            begin
                // Wrap to the start of the next text row
                cx_next = '0;
                cy_next = y_sum[CY_W-1:0];
                if (y_sum > MAX_Y)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                cx_next = x_sum[CX_W-1:0];
            end
        end

        pg   = y[CY_W-1:3];
        addr = AW'(pg) * AW'(DISPLAY_WIDTH) + AW'(x);

        res.emit              = has_ch && ({1'b0, x} <= MAX_X);
        res.item.glyph_index  = glyph_of(ch);
        res.item.byte_address = addr[ADDR_W-1:0];
        res.item.column       = x[COLUMN_W-1:0];
        res.item.page         = pg[PAGE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            lead_reg   <= 1'b0;
            lbits_reg  <= 2'b00;
            active_reg <= 1'b0;
        end
        else if (step_en)
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            lead_reg   <= lead_next;
            lbits_reg  <= lbits_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== src/utcg_out_stage.sv =====
// Result register: holds one glyph transaction until the receiver takes it.
// Depends on utcg_pkg (glyph_item_t, step_res_t).
module utcg_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  utcg_pkg::step_res_t   res,
    output logic                  space,
    output logic                  glyph_valid,
    input  logic                  glyph_ready,
    output utcg_pkg::glyph_item_t glyph_item
);
    import utcg_pkg::*;

    logic        valid_reg, valid_next;
    glyph_item_t data_reg;

    assign space       = !valid_reg || glyph_ready;
    assign glyph_valid = valid_reg;
    assign glyph_item  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && res.emit)
        begin
            valid_next = 1'b1;
        end
        else if (glyph_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.emit)
        begin
            data_reg <= res.item;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for utf8_text_cursor_glyph_mapper_top: a directed table of
// text transactions, then random UTF-8 strings, every glyph checked against the table or a cursor model.
// Depends on utcg_pkg and the RTL under src.
module testbench;

    import utcg_pkg::*;

    localparam int MAX_X        = DISPLAY_WIDTH_DEF - CHAR_STEP;
    localparam int MAX_Y        = DISPLAY_HEIGHT_DEF - CHAR_ROWS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 95;

    localparam logic [2:0] LEAD2_MARK = 3'b110;

    // Latin-1 codes of glyphs 63 to 91, glyph 63 in the top byte
    localparam logic [29*8-1:0] EXTRA_CODES = {
        8'h2E, 8'h3A, 8'h23, 8'h21, 8'h3F, 8'hC3, 8'hC2, 8'hC1, 8'hC0, 8'hC9,
        8'hCA, 8'hCD, 8'hD3, 8'hD4, 8'hD5, 8'hDA, 8'hC7, 8'hE7, 8'hE3, 8'hE1,
        8'hE0, 8'hE2, 8'hE9, 8'hEA, 8'hED, 8'hF3, 8'hF4, 8'hFA, 8'h2C
    };
    localparam string GLYPH_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.:#!?, ";

    typedef struct {
        text_item_t  item;
        bit          typed;
        bit          emit;
        glyph_item_t glyph;
    } text_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        text_valid  = 1'b0;
    logic        glyph_ready = 1'b0;
    text_item_t  text_item   = '0;
    logic        text_ready;
    logic        glyph_valid;
    glyph_item_t glyph_item;

    // Cursor model state
    logic [7:0] pen_x     = '0;
    logic [6:0] pen_y     = '0;
    logic       held_lead = 1'b0;
    logic [1:0] held_bits = '0;
    logic       text_open = 1'b0;

    glyph_item_t pending_glyphs[$];
    text_row_t   text_script[$];

    int error_count    = 0;
    int cycle_count    = 0;
    int live_items     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    utf8_text_cursor_glyph_mapper_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_item   (text_item),
        .glyph_valid (glyph_valid),
        .glyph_ready (glyph_ready),
        .glyph_item  (glyph_item)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [GLYPH_W-1:0] glyph_number(input logic [7:0] code);
        if (code >= "A" && code <= "Z")
            return GLYPH_W'(code - "A" + 1);
        if (code >= "0" && code <= "9")
            return GLYPH_W'(code - "0" + 27);
        if (code >= "a" && code <= "z")
            return GLYPH_W'(code - "a" + 37);
        for (int i = 0; i < 29; i++)
        begin
            if (EXTRA_CODES[8*(28-i) +: 8] == code)
                return GLYPH_W'(63 + i);
        end
        return GLYPH_BLANK;
    endfunction

    // Advance the cursor model by one text byte; return 1 when a glyph lands on screen
    function automatic bit step_cursor(input text_item_t it, output glyph_item_t g,
                                       output bit used);
        logic [7:0] code;
        int         pg;
        bit         emit;
        g    = '0;
        used = 1'b0;
        emit = 1'b0;
        if (it.starts_string)
        begin
            pen_x     = {1'b0, it.start_x};
            pen_y     = {1'b0, it.start_y};
            held_lead = 1'b0;
            held_bits = '0;
            text_open = 1'b1;
        end
        if (text_open && pen_y > MAX_Y)
            text_open = 1'b0;
        if (!text_open)
            return 1'b0;
        used = 1'b1;
        if (it.text_byte == CH_NUL)
        begin
            held_lead = 1'b0;
            held_bits = '0;
            text_open = 1'b0;
            return 1'b0;
        end
        if (held_lead)
        begin
            // any nonzero byte completes the pair, well-formed or not
            code      = {held_bits, it.text_byte[5:0]};
            held_lead = 1'b0;
            held_bits = '0;
        end
        else if (!it.text_byte[7])
            code = it.text_byte;
        else if (it.text_byte[7:5] == LEAD2_MARK)
        begin
            held_lead = 1'b1;
            held_bits = it.text_byte[1:0];
            return 1'b0;
        end
        else
            return 1'b0;

        if (pen_x <= MAX_X)
        begin
            pg             = pen_y >> 3;
            g.glyph_index  = glyph_number(code);
            g.byte_address = ADDR_W'(pg * DISPLAY_WIDTH_DEF + pen_x);
            g.column       = pen_x[COLUMN_W-1:0];
            g.page         = pg[PAGE_W-1:0];
            emit           = 1'b1;
        end
        pen_x = pen_x + 8'(CHAR_STEP);
        if (pen_x > MAX_X)
        begin
            pen_x = '0;
            pen_y = pen_y + 7'(CHAR_ROWS);
            if (pen_y > MAX_Y)
                text_open = 1'b0;
        end
        return emit;
    endfunction

    function automatic text_row_t mk_row(input logic [7:0] b, input bit s,
                                         input logic [6:0] x, input logic [5:0] y);
        text_row_t r;
        r.item.text_byte     = b;
        r.item.starts_string = s;
        r.item.start_x       = x;
        r.item.start_y       = y;
        r.typed              = 1'b0;
        r.emit               = 1'b0;
        r.glyph              = '0;
        return r;
    endfunction

    function automatic text_row_t mk_typed(input logic [7:0] b, input bit s,
                                           input logic [6:0] x, input logic [5:0] y,
                                           input bit emit, input int gi, input int addr,
                                           input int col, input int pg);
        text_row_t r;
        r                    = mk_row(b, s, x, y);
        r.typed              = 1'b1;
        r.emit               = emit;
        r.glyph.glyph_index  = GLYPH_W'(gi);
        r.glyph.byte_address = ADDR_W'(addr);
        r.glyph.column       = COLUMN_W'(col);
        r.glyph.page         = PAGE_W'(pg);
        return r;
    endfunction

    // Offer one transaction, hold it until accepted, then log what it should produce
    task automatic send_text(input text_item_t it, input bit typed, input bit t_emit,
                             input glyph_item_t t_glyph);
        glyph_item_t g;
        bit          emit;
        bit          used;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= it;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        emit = step_cursor(it, g, used);
        if (typed)
        begin
            emit = t_emit;
            g    = t_glyph;
        end
        if (emit)
            pending_glyphs.push_back(g);
        if (used)
            live_items++;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit s, input logic [6:0] x,
                             input logic [5:0] y);
        text_row_t r;
        r = mk_row(b, s, x, y);
        send_text(r.item, 1'b0, 1'b0, '0);
    endtask

    // One character: mostly glyph-set ASCII and two-byte sequences, some junk
    task automatic send_char(input bit s, input logic [6:0] x, input logic [5:0] y);
        int kind;
        logic [7:0] lead;
        logic [7:0] tail;
        kind = $urandom_range(99);
        if (kind < 45)
            send_byte(GLYPH_CHARS[$urandom_range(GLYPH_CHARS.len() - 1)], s, x, y);
        else if (kind < 60)
            send_byte(8'($urandom_range(1, 127)), s, x, y);
        else if (kind < 88)
        begin
            lead = ($urandom_range(3) != 0) ? 8'($urandom_range(8'hC2, 8'hC3))
                                            : 8'($urandom_range(8'hC0, 8'hDF));
            tail = ($urandom_range(3) != 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                            : 8'($urandom_range(1, 255));
            send_byte(lead, s, x, y);
            send_byte(tail, 1'b0, x, y);
        end
        else if (kind < 95)
            send_byte($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                        : 8'($urandom_range(8'hE0, 8'hFF)), s, x, y);
        else
            send_byte(CH_NUL, s, x, y);
    endtask

    task automatic send_string(input int n);
        logic [6:0] x;
        logic [5:0] y;
        x = $urandom_range(1) ? 7'(CHAR_STEP * $urandom_range(15)) : 7'($urandom_range(127));
        y = ($urandom_range(99) < 85) ? 6'($urandom_range(MAX_Y)) : 6'($urandom_range(63));
        send_char(1'b1, x, y);
        for (int i = 1; i < n; i++)
            send_char(1'b0, x, y);
        if ($urandom_range(99) < 60)
            send_byte(CH_NUL, 1'b0, x, y);
    endtask

    task automatic send_noise();
        send_byte(8'($urandom), 1'($urandom), 7'($urandom), 6'($urandom));
    endtask

    // Stop offering and wait for every outstanding glyph
    task automatic drain_glyphs();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_glyphs.size() != 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : recv_side
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            glyph_ready <= 1'b0;
        end
        else
            glyph_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : glyph_monitor
        glyph_item_t want;
        if (rst_n && glyph_valid && glyph_ready)
        begin
            if (pending_glyphs.size() == 0)
            begin
                $error("unexpected glyph transaction: glyph_index %0d, byte_address %0d",
                       glyph_item.glyph_index, glyph_item.byte_address);
                error_count++;
            end
            else
            begin
                want = pending_glyphs.pop_front();
                check_field("glyph_index", want.glyph_index, glyph_item.glyph_index);
                check_field("byte_address", want.byte_address, glyph_item.byte_address);
                check_field("column", want.column, glyph_item.column);
                check_field("page", want.page, glyph_item.page);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int target;
        // no string open after reset: ignore
        text_script.push_back(mk_typed("A", 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_typed("A", 1'b1, 7'd0, 6'd0, 1'b1, 1, 0, 0, 0));
        text_script.push_back(mk_typed("z", 1'b0, 7'd0, 6'd0, 1'b1, 62, 8, 8, 0));
        text_script.push_back(mk_typed("0", 1'b0, 7'd0, 6'd0, 1'b1, 27, 16, 16, 0));
        text_script.push_back(mk_typed("9", 1'b0, 7'd0, 6'd0, 1'b1, 36, 24, 24, 0));
        // two-byte Latin-1, then a lead joined with a plain letter, then lead after lead
        text_script.push_back(mk_typed(8'hC3, 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_row(8'hA7, 1'b0, 7'd0, 6'd0));
        text_script.push_back(mk_typed(8'hDF, 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_row("A", 1'b0, 7'd0, 6'd0));
        text_script.push_back(mk_typed(8'hC0, 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_row(8'hC1, 1'b0, 7'd0, 6'd0));
        // skipped bytes, then DEL, which maps to the blank glyph
        text_script.push_back(mk_typed(8'h80, 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_typed(8'hFF, 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_typed(8'hE0, 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_row(8'h7F, 1'b0, 7'd0, 6'd0));
        // zero drops a pending lead and closes the string
        text_script.push_back(mk_typed(8'hC2, 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_typed(CH_NUL, 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_typed("A", 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        // last cell on screen, then screen full
        text_script.push_back(mk_typed("#", 1'b1, 7'd120, 6'd56, 1'b1, 65, 1016, 120, 7));
        text_script.push_back(mk_typed("B", 1'b0, 7'd0, 6'd0, 1'b0, 0, 0, 0, 0));
        // glyph off the right edge: no transaction, cursor still wraps
        text_script.push_back(mk_typed("A", 1'b1, 7'd127, 6'd0, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_typed(",", 1'b0, 7'd0, 6'd0, 1'b1, 91, 128, 0, 1));
        // start row below the last text row closes at once
        text_script.push_back(mk_typed("A", 1'b1, 7'd0, 6'd63, 1'b0, 0, 0, 0, 0));
        // a new start drops a pending lead
        text_script.push_back(mk_typed(8'hC3, 1'b1, 7'd64, 6'd32, 1'b0, 0, 0, 0, 0));
        text_script.push_back(mk_row("?", 1'b1, 7'd5, 6'd40));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (text_script[i])
            send_text(text_script[i].item, text_script[i].typed, text_script[i].emit,
                      text_script[i].glyph);

        for (int p = 0; p < 4; p++)
        begin
            drain_glyphs();
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (p == 0)
            begin
                // hold the glyph side off while a full-width string keeps coming
                hold_request = 60;
                send_byte("H", 1'b1, 7'd0, 6'd0);
                for (int i = 0; i < 30; i++)
                    send_byte(GLYPH_CHARS[$urandom_range(GLYPH_CHARS.len() - 1)],
                              1'b0, 7'd0, 6'd0);
            end
            target = live_items + PHASE_ITEMS;
            while (live_items < target)
            begin
                if ($urandom_range(99) < 80)
                    send_string($urandom_range(1, 24));
                else
                    repeat ($urandom_range(1, 4)) send_noise();
            end
        end

        drain_glyphs();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/utcg_pkg.sv
src/utcg_cursor.sv
src/utcg_out_stage.sv
src/utf8_text_cursor_glyph_mapper_top.sv
verif/testbench.sv
